// ===== src/lcs_pkg.sv =====
`timescale 1ns / 1ps

package lcs_pkg;

  // Field widths
  localparam int unsigned SpeedBits = 10;
  localparam int unsigned AngleBits = 16;
  localparam int unsigned AddrBits  = 3;
  localparam int unsigned DataBits  = 32;

  // Full turn of 360 degrees in 1/128 degree
  localparam logic [AngleBits-1:0] FullTurn = 16'd46080;

  localparam logic [15:0] RestAngleReset  = 16'd5760;
  localparam logic [15:0] AngleSlopeReset = 16'hFC29;  // -983

  // Register word index, taken from paddr[2]
  localparam logic RegRestAngle  = 1'b0;
  localparam logic RegAngleSlope = 1'b1;

  typedef enum logic [1:0] {
    OpPosition = 2'd0,
    OpRequest  = 2'd1,
    OpTick     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MoveNone  = 2'd0,
    MoveLeft  = 2'd1,
    MoveRight = 2'd2
  } move_e;

  // Lane position codes
  localparam logic [2:0] PosCentred      = 3'd0;
  localparam logic [2:0] PosRightCentred = 3'd2;
  localparam logic [2:0] PosDriftLeft    = 3'd3;
  localparam logic [2:0] PosDriftRight   = 3'd4;

  // Requested direction codes
  localparam logic [1:0] DirLeft  = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;

  typedef struct packed {
    logic [1:0]           op;
    logic [1:0]           available_lanes;
    logic [2:0]           lane_position;
    logic [1:0]           requested_direction;
    logic [SpeedBits-1:0] speed;
  } lcs_in_t;

  typedef struct packed {
    logic                 steer_valid;
    logic [AngleBits-1:0] steer_direction;
    logic                 request_error;
  } lcs_out_t;

  // Decision of the sequencer for one item
  typedef struct packed {
    logic  steer_valid;
    move_e move;
    logic  request_error;
  } lcs_act_t;

endpackage

// ===== src/lcs_ctrl.sv =====
`timescale 1ns / 1ps

module lcs_ctrl import lcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  lcs_in_t  item_i,
  output lcs_act_t act_o
);

  logic [1:0] lanes_q, lanes_d;
  logic [2:0] pos_q, pos_d;
  logic [2:0] target_q, target_d;
  move_e      wanted_q, wanted_d;
  move_e      active_q, active_d;
  move_e      start_move;

  always_comb begin
    lanes_d    = lanes_q;
    pos_d      = pos_q;
    target_d   = target_q;
    wanted_d   = wanted_q;
    active_d   = active_q;
    start_move = MoveNone;
    act_o      = '{steer_valid: 1'b0, move: MoveNone, request_error: 1'b0};

    case (item_i.op)
      OpPosition: begin
        pos_d = item_i.lane_position;
        if (item_i.lane_position == PosDriftLeft || item_i.lane_position == PosDriftRight) begin
          lanes_d = '0;
        end else if (item_i.lane_position inside {[PosCentred:PosRightCentred]}) begin
          lanes_d = item_i.available_lanes;
        end
      end
      OpRequest: begin
        // bit 0: left lane open, bit 1: right lane open
        if (item_i.requested_direction == DirLeft && lanes_q[0]) begin
          wanted_d = MoveLeft;
        end else if (item_i.requested_direction == DirRight && lanes_q[1]) begin
          wanted_d = MoveRight;
        end else begin
          wanted_d            = MoveNone;
          act_o.request_error = 1'b1;
        end
      end
      OpTick: begin
        if (active_q == MoveNone) begin
          target_d = PosCentred;
          if (pos_q == PosDriftLeft) begin
            start_move = MoveRight;
          end else if (pos_q == PosDriftRight) begin
            start_move = MoveLeft;
          end else if (wanted_q == MoveLeft) begin
            start_move = MoveLeft;
            target_d   = PosDriftRight;
          end else if (wanted_q == MoveRight) begin
            start_move = MoveRight;
            target_d   = PosDriftLeft;
          end
          if (start_move != MoveNone) begin
            active_d          = start_move;
            act_o.steer_valid = 1'b1;
            act_o.move        = start_move;
          end
        end else if (pos_q == target_q) begin
          // manoeuvre complete: straighten up
          act_o.steer_valid = 1'b1;
          wanted_d          = MoveNone;
          active_d          = MoveNone;
          target_d          = PosCentred;
        end else begin
          act_o.steer_valid = 1'b1;
          act_o.move        = active_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q  <= '0;
      pos_q    <= PosCentred;
      target_q <= PosCentred;
      wanted_q <= MoveNone;
      active_q <= MoveNone;
    end else if (en_i) begin
      lanes_q  <= lanes_d;
      pos_q    <= pos_d;
      target_q <= target_d;
      wanted_q <= wanted_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== src/lane_change_sequencer.sv =====
`timescale 1ns / 1ps

// Lane change sequencer.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries position updates,
// lane requests and task ticks; every accepted transaction gives exactly one
// result transaction on out_valid_o / out_stall_i / out_data_o, in order.
// out_valid_o rises once the item reaches the result register, which waits while the
// output is stalled: an input register, then the sequencer state update and the angle
// multiply-add (speed times angle slope plus rest angle), saturation and
// left/right selection feed the result register.
// Throughput is one transaction per cycle without stalls; the state is updated as each item
// moves into the result register, so consecutive items see each other's effect.
// While out_stall_i is high the result holds and the input register fills;
// in_stall_o rises only once both stages are occupied.
// Reset clears the pipeline and the sequencer state (no lanes open, centred,
// no move) and loads rest_angle = 5760 and angle_slope = -983.
// APB registers: rest_angle at 0x0, angle_slope at 0x4; pready is always high.
module lane_change_sequencer import lcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcs_out_t            out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready
);

  localparam int unsigned ProdW = SpeedBits + 17;
  localparam int unsigned RestW = 25;
  localparam int unsigned SumW  = ((ProdW > RestW) ? ProdW : RestW) + 1;

  logic [15:0]        rest_q;
  logic signed [15:0] slope_q;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q  <= RestAngleReset;
      slope_q <= AngleSlopeReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegRestAngle:  rest_q  <= pwdata[15:0];
        RegAngleSlope: slope_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegRestAngle:  prdata = {16'h0000, rest_q};
      RegAngleSlope: prdata = {16'h0000, slope_q};
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  logic v1_q, vo_q;
  logic r1, ro;

  assign ro         = !vo_q || !out_stall_i;
  assign r1         = !v1_q || ro;
  assign in_stall_o = !r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= in_valid_i;
      end
      if (ro) begin
        vo_q <= v1_q;
      end
    end
  end

  // input register
  lcs_in_t s1_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && r1) begin
      s1_q <= in_data_i;
    end
  end

  // sequencer decision and angle
  lcs_act_t                 act;
  logic                     adv_out;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   sum;
  logic [SumW-9:0]          shifted;
  logic [AngleBits-1:0]     ang;
  logic [AngleBits-1:0]     steer;

  assign adv_out = v1_q && ro;

  lcs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv_out),
    .item_i (s1_q),
    .act_o  (act)
  );

  always_comb begin
    prod    = ProdW'($signed({1'b0, s1_q.speed}) * slope_q);
    sum     = SumW'($signed({1'b0, rest_q, 8'h00})) + SumW'(prod);
    shifted = sum[SumW-1:8];
    if (sum[SumW-1]) begin
      ang = '0;
    end else if (shifted > (SumW-8)'(FullTurn)) begin
      ang = FullTurn;
    end else begin
      ang = shifted[AngleBits-1:0];
    end

    case (act.move)
      MoveLeft:  steer = ang;
      MoveRight: steer = FullTurn - ang;
      default:   steer = '0;
    endcase
  end

  lcs_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_q.steer_valid     <= act.steer_valid;
      out_q.steer_direction <= steer;
      out_q.request_error   <= act.request_error;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/lcs_checker.sv =====
`timescale 1ns / 1ps

module lcs_checker import lcs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input lcs_out_t out_data_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // with the result register empty the pipeline drains, so input is never stalled
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.steer_direction <= FullTurn)
    else $error("steering direction beyond full turn");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.steer_valid |-> out_data_o.steer_direction == '0)
    else $error("steering direction without steering command");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.steer_valid && out_data_o.request_error))
    else $error("tick and request result mixed");

endmodule

bind lane_change_sequencer lcs_checker u_lcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
